// ===== sv/vrl_pkg.sv =====
`default_nettype none
package vrl_pkg;

   // ring geometry
   localparam int BUF_BYTES      = 4096;
   localparam int ALIGN_BYTES    = 8;
   localparam int ALIGN_SHIFT    = $clog2(ALIGN_BYTES);
   localparam int HEADER_BYTES   = 80;
   localparam int LEN_WORD_BYTES = 8;
   localparam int SLOT_COUNT     = BUF_BYTES / ALIGN_BYTES;
   localparam int SLOT_W         = $clog2(SLOT_COUNT);

   // field widths
   localparam int OP_W    = 3;
   localparam int PATH_W  = 12;
   localparam int ST_W    = 2;
   localparam int IDX_W   = 12;
   localparam int SEQ_W   = 64;
   localparam int BYTES_W = 13;
   localparam int DROP_W  = 10;
   localparam int WIDE_W  = IDX_W + 2;

   // opcodes
   localparam logic [OP_W-1:0] OP_APPEND     = 3'd0;
   localparam logic [OP_W-1:0] OP_READ_NEXT  = 3'd1;
   localparam logic [OP_W-1:0] OP_SEEK_FIRST = 3'd2;
   localparam logic [OP_W-1:0] OP_SEEK_END   = 3'd3;
   localparam logic [OP_W-1:0] OP_POLL       = 3'd4;

   // status codes
   localparam logic [ST_W-1:0] STAT_OK      = 2'd0;
   localparam logic [ST_W-1:0] STAT_EMPTY   = 2'd1;
   localparam logic [ST_W-1:0] STAT_OVERRUN = 2'd2;
   localparam logic [ST_W-1:0] STAT_TOO_BIG = 2'd3;

   typedef struct packed {
      logic [ST_W-1:0]    status;
      logic [IDX_W-1:0]   record_index;
      logic [SEQ_W-1:0]   record_seq;
      logic [BYTES_W-1:0] record_bytes;
      logic [DROP_W-1:0]  dropped_count;
   } res_type;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
      slot_of = idx[IDX_W-1:ALIGN_SHIFT];
   endfunction

endpackage
`default_nettype wire

// ===== sv/vrl_ifs.sv =====
`default_nettype none
interface vrl_req_if import vrl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [PATH_W-1:0] path_bytes;

   modport source (output valid, opcode, path_bytes, input ready);
   modport sink (input valid, opcode, path_bytes, output ready);
endinterface

interface vrl_rsp_if import vrl_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ST_W-1:0]    status;
   logic [IDX_W-1:0]   record_index;
   logic [SEQ_W-1:0]   record_seq;
   logic [BYTES_W-1:0] record_bytes;
   logic [DROP_W-1:0]  dropped_count;

   modport source (output valid, status, record_index, record_seq, record_bytes,
                   dropped_count, input ready);
   modport sink (input valid, status, record_index, record_seq, record_bytes,
                 dropped_count, output ready);
endinterface
`default_nettype wire

// ===== sv/variable_record_log_ring.sv =====
`default_nettype none
// channel   | ports       | direction | word
// ----------+-------------+-----------+------------------------------------------
// request   | req_chan.*  | in        | opcode, path_bytes
// response  | rsp_chan.*  | out       | status, record_index, record_seq,
//           |             |           | record_bytes, dropped_count
//
// An append walks the length memory one registered read at a time for each
// record it drops, and a read-next walks it for the record it reads.
// Reset is synchronous and clears state, pointers, counters and output valid only.
// A one-word output register decouples the response side; while it is full and
// not being taken, the core holds its finished word and takes no request.
module variable_record_log_ring import vrl_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   vrl_req_if.sink   req_chan,
   vrl_rsp_if.source rsp_chan
);

   logic               res_valid;
   logic               res_ready;
   res_type            res;
   logic               ram_we;
   logic [SLOT_W-1:0]  ram_waddr;
   logic [BYTES_W-1:0] ram_wdata;
   logic               ram_re;
   logic [SLOT_W-1:0]  ram_raddr;
   logic [BYTES_W-1:0] ram_rdata;

   logic               rsp_valid_ff, rsp_valid_in;
   res_type            rsp_ff, rsp_in;

   vrl_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   vrl_ram #(
      .WIDTH (BYTES_W),
      .DEPTH (SLOT_COUNT)
   ) u_len_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign res_ready = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_ff.status;
   assign rsp_chan.record_index  = rsp_ff.record_index;
   assign rsp_chan.record_seq    = rsp_ff.record_seq;
   assign rsp_chan.record_bytes  = rsp_ff.record_bytes;
   assign rsp_chan.dropped_count = rsp_ff.dropped_count;

endmodule
`default_nettype wire

// ===== sv/vrl_ram.sv =====
`default_nettype none
module vrl_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

// ===== sv/vrl_core.sv =====
`default_nettype none
module vrl_core import vrl_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   vrl_req_if.sink               req_chan,
   output      logic             res_valid,
   input  wire logic             res_ready,
   output      res_type          res,
   output      logic             ram_we,
   output      logic [SLOT_W-1:0]  ram_waddr,
   output      logic [BYTES_W-1:0] ram_wdata,
   output      logic             ram_re,
   output      logic [SLOT_W-1:0]  ram_raddr,
   input  wire logic [BYTES_W-1:0] ram_rdata
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_DROP  = 8'b0000_0010,
      S_WALK1 = 8'b0000_0100,
      S_WALK2 = 8'b0000_1000,
      S_WALK3 = 8'b0001_0000,
      S_OVR   = 8'b0010_0000,
      S_PUT   = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   oldest_index_ff, oldest_index_in;
   logic [SEQ_W-1:0]   oldest_seq_ff, oldest_seq_in;
   logic [IDX_W-1:0]   write_index_ff, write_index_in;
   logic [SEQ_W-1:0]   write_seq_ff, write_seq_in;
   logic [IDX_W-1:0]   reader_index_ff, reader_index_in;
   logic [SEQ_W-1:0]   reader_seq_ff, reader_seq_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [BYTES_W-1:0] size_ff, size_in;
   logic [DROP_W-1:0]  dropped_ff, dropped_in;
   logic [IDX_W-1:0]   walk_idx_ff, walk_idx_in;
   logic [IDX_W-1:0]   walk_at_ff, walk_at_in;
   logic [IDX_W-1:0]   walk_nxt_ff, walk_nxt_in;
   res_type            res_ff, res_in;

   logic [WIDE_W-1:0]  size_sum;
   logic [BYTES_W-1:0] size_calc;
   logic               too_big;
   logic [BYTES_W-1:0] tail;
   logic [BYTES_W-1:0] gap;
   logic [BYTES_W-1:0] need;
   logic               drop_go;
   logic               wrap_need;
   logic [WIDE_W-1:0]  nxt;
   logic [IDX_W-1:0]   walk_at_calc;
   logic               walk_end;
   logic [IDX_W-1:0]   walk_res;
   logic [ST_W-1:0]    poll_status;

   // aligned record size straight from the request word
   assign size_sum  = WIDE_W'(req_chan.path_bytes)
                    + WIDE_W'(HEADER_BYTES + 1 + ALIGN_BYTES - 1);
   assign size_calc = {size_sum[BYTES_W-1:ALIGN_SHIFT], ALIGN_SHIFT'(0)};
   assign too_big   = (WIDE_W'(size_calc) + WIDE_W'(LEN_WORD_BYTES))
                    >= WIDE_W'(BUF_BYTES);

   // free contiguous space ahead of the write pointer
   assign tail = BYTES_W'(BUF_BYTES) - BYTES_W'(write_index_ff);
   always_comb begin
      if (write_index_ff > oldest_index_ff) begin
         gap = (tail > BYTES_W'(oldest_index_ff)) ? tail : BYTES_W'(oldest_index_ff);
      end else begin
         gap = BYTES_W'(oldest_index_ff - write_index_ff);
      end
   end
   assign need      = size_ff + BYTES_W'(LEN_WORD_BYTES);
   assign drop_go   = (oldest_seq_ff < write_seq_ff)
                    && (dropped_ff <= DROP_W'(SLOT_COUNT))
                    && !(gap > need);
   assign wrap_need = (WIDE_W'(write_index_ff) + WIDE_W'(size_ff)
                    + WIDE_W'(LEN_WORD_BYTES)) >= WIDE_W'(BUF_BYTES);

   assign nxt          = WIDE_W'(walk_at_ff) + WIDE_W'(ram_rdata);
   assign walk_at_calc = (ram_rdata == '0) ? '0 : walk_idx_ff;

   always_comb begin
      poll_status = STAT_EMPTY;
      if (reader_seq_ff < write_seq_ff) begin
         poll_status = (reader_seq_ff < oldest_seq_ff) ? STAT_OVERRUN : STAT_OK;
      end
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign res_valid      = (state_ff == S_DONE);
   assign res            = res_ff;

   always_comb begin
      state_in        = state_ff;
      oldest_index_in = oldest_index_ff;
      oldest_seq_in   = oldest_seq_ff;
      write_index_in  = write_index_ff;
      write_seq_in    = write_seq_ff;
      reader_index_in = reader_index_ff;
      reader_seq_in   = reader_seq_ff;
      op_in           = op_ff;
      size_in         = size_ff;
      dropped_in      = dropped_ff;
      walk_idx_in     = walk_idx_ff;
      walk_at_in      = walk_at_ff;
      walk_nxt_in     = walk_nxt_ff;
      res_in          = res_ff;
      ram_we          = 1'b0;
      ram_waddr       = slot_of(write_index_ff);
      ram_wdata       = '0;
      ram_re          = 1'b0;
      ram_raddr       = slot_of(oldest_index_ff);
      walk_end        = 1'b0;
      walk_res        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in      = req_chan.opcode;
               size_in    = size_calc;
               dropped_in = '0;
               res_in     = '{STAT_OK, reader_index_ff, reader_seq_ff, '0, '0};
               state_in   = S_DONE;
               unique case (req_chan.opcode)
                  OP_APPEND: begin
                     if (too_big) begin
                        res_in = '{STAT_TOO_BIG, write_index_ff, write_seq_ff,
                                   size_calc, '0};
                     end else begin
                        state_in = S_DROP;
                     end
                  end
                  OP_READ_NEXT: begin
                     if (reader_seq_ff >= write_seq_ff) begin
                        res_in.status = STAT_EMPTY;
                     end else if (reader_seq_ff < oldest_seq_ff) begin
                        ram_re    = 1'b1;
                        ram_raddr = slot_of(oldest_index_ff);
                        state_in  = S_OVR;
                     end else begin
                        walk_idx_in = reader_index_ff;
                        ram_re      = 1'b1;
                        ram_raddr   = slot_of(reader_index_ff);
                        state_in    = S_WALK1;
                     end
                  end
                  OP_SEEK_FIRST: begin
                     reader_index_in = oldest_index_ff;
                     reader_seq_in   = oldest_seq_ff;
                     res_in = '{STAT_OK, oldest_index_ff, oldest_seq_ff, '0, '0};
                  end
                  OP_SEEK_END: begin
                     reader_index_in = write_index_ff;
                     reader_seq_in   = write_seq_ff;
                     res_in = '{STAT_OK, write_index_ff, write_seq_ff, '0, '0};
                  end
                  OP_POLL: begin
                     res_in.status = poll_status;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DROP: begin
            if (drop_go) begin
               walk_idx_in = oldest_index_ff;
               ram_re      = 1'b1;
               ram_raddr   = slot_of(oldest_index_ff);
               state_in    = S_WALK1;
            end else begin
               if (wrap_need) begin
                  // zero length word marks the wrap back to index 0
                  ram_we         = 1'b1;
                  ram_waddr      = slot_of(write_index_ff);
                  ram_wdata      = '0;
                  write_index_in = '0;
               end
               state_in = S_PUT;
            end
         end
         S_WALK1: begin
            walk_at_in = walk_at_calc;
            ram_re     = 1'b1;
            ram_raddr  = slot_of(walk_at_calc);
            state_in   = S_WALK2;
         end
         S_WALK2: begin
            if (op_ff == OP_READ_NEXT) begin
               res_in = '{STAT_OK, walk_at_ff, reader_seq_ff, ram_rdata, '0};
            end
            if (nxt >= WIDE_W'(BUF_BYTES)) begin
               walk_end = 1'b1;
               walk_res = '0;
            end else begin
               walk_nxt_in = nxt[IDX_W-1:0];
               ram_re      = 1'b1;
               ram_raddr   = slot_of(nxt[IDX_W-1:0]);
               state_in    = S_WALK3;
            end
         end
         S_WALK3: begin
            walk_end = 1'b1;
            walk_res = (ram_rdata == '0) ? '0 : walk_nxt_ff;
         end
         S_OVR: begin
            reader_index_in = (ram_rdata == '0) ? '0 : oldest_index_ff;
            reader_seq_in   = oldest_seq_ff;
            res_in = '{STAT_OVERRUN, reader_index_in, oldest_seq_ff, '0, '0};
            state_in = S_DONE;
         end
         S_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = slot_of(write_index_ff);
            ram_wdata = size_ff;
            if (oldest_seq_ff == write_seq_ff) begin
               oldest_index_in = write_index_ff;
            end
            write_index_in = IDX_W'(WIDE_W'(write_index_ff) + WIDE_W'(size_ff));
            write_seq_in   = write_seq_ff + SEQ_W'(1);
            res_in = '{STAT_OK, write_index_ff, write_seq_ff, size_ff, dropped_ff};
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // walker finished: either one dropped record or one read record
      if (walk_end) begin
         if (op_ff == OP_APPEND) begin
            oldest_index_in = walk_res;
            oldest_seq_in   = oldest_seq_ff + SEQ_W'(1);
            dropped_in      = dropped_ff + DROP_W'(1);
            state_in        = S_DROP;
         end else begin
            reader_index_in = walk_res;
            reader_seq_in   = reader_seq_ff + SEQ_W'(1);
            state_in        = S_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         oldest_index_ff <= '0;
         oldest_seq_ff   <= '0;
         write_index_ff  <= '0;
         write_seq_ff    <= '0;
         reader_index_ff <= '0;
         reader_seq_ff   <= '0;
         dropped_ff      <= '0;
      end else begin
         state_ff        <= state_in;
         oldest_index_ff <= oldest_index_in;
         oldest_seq_ff   <= oldest_seq_in;
         write_index_ff  <= write_index_in;
         write_seq_ff    <= write_seq_in;
         reader_index_ff <= reader_index_in;
         reader_seq_ff   <= reader_seq_in;
         dropped_ff      <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      size_ff     <= size_in;
      walk_idx_ff <= walk_idx_in;
      walk_at_ff  <= walk_at_in;
      walk_nxt_ff <= walk_nxt_in;
      res_ff      <= res_in;
   end

   a_seq_order: assert property (@(posedge clock) disable iff (reset)
      oldest_seq_ff <= write_seq_ff)
      else $error("oldest sequence passed write sequence");

   a_write_aligned: assert property (@(posedge clock) disable iff (reset)
      write_index_ff[ALIGN_SHIFT-1:0] == '0)
      else $error("write index lost alignment");

   a_ram_one_access: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("length memory read and written in one cycle");

   a_drop_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DROP) |-> (dropped_ff <= DROP_W'(SLOT_COUNT + 1)))
      else $error("drop count beyond slot count");

endmodule
`default_nettype wire

// ===== tb/sv/variable_record_log_ring_test.sv =====
`timescale 1ns / 100ps

module variable_record_log_ring_test import vrl_pkg::*; ();

   // records this large can force a drop of the newest record on the next append,
   // so they are only placed when the slot behind them already holds a length
   localparam int GIANT_BYTES = 3800;

   class ring_bookkeeper;
      int unsigned     oldest_idx, write_idx, reader_idx;
      longint unsigned oldest_seq, write_seq, reader_seq;
      int unsigned     lens [SLOT_COUNT];
      bit              written [SLOT_COUNT];
      bit              touched_blank;
      res_type         pending_words [$];
      int              bad;
      int              n_words, n_appends, n_wraps, n_dropped, n_too_big;
      int              n_reads, n_overruns, n_empty;

      function new();
         oldest_idx = 0; write_idx = 0; reader_idx = 0;
         oldest_seq = 0; write_seq = 0; reader_seq = 0;
         foreach (lens[i]) begin
            lens[i] = 0;
            written[i] = 1'b0;
         end
         bad = 0; n_words = 0; n_appends = 0; n_wraps = 0; n_dropped = 0;
         n_too_big = 0; n_reads = 0; n_overruns = 0; n_empty = 0;
      endfunction

      function int unsigned slot_len(int unsigned idx);
         int unsigned s;
         s = idx / ALIGN_BYTES;
         if (s >= SLOT_COUNT) return 0;
         if (!written[s]) touched_blank = 1'b1;
         return written[s] ? lens[s] : 0;
      endfunction

      // a zero length word is a wrap marker and stands for index 0
      function int unsigned settle(int unsigned idx);
         if (idx >= BUF_BYTES) return 0;
         return (slot_len(idx) == 0) ? 0 : idx;
      endfunction

      function int unsigned step_over(int unsigned idx);
         int unsigned at;
         at = settle(idx);
         return settle(at + slot_len(at));
      endfunction

      function res_type pack_word(logic [ST_W-1:0] st, int unsigned idx, longint unsigned seq,
                                  int unsigned bytes, int unsigned dropped);
         res_type w;
         w.status        = st;
         w.record_index  = idx[IDX_W-1:0];
         w.record_seq    = seq;
         w.record_bytes  = bytes[BYTES_W-1:0];
         w.dropped_count = dropped[DROP_W-1:0];
         return w;
      endfunction

      // Works out the word for one request; state and lengths change only on commit.
      // unsafe flags a lookup of a length slot that was never written.
      function void foresee(input logic [OP_W-1:0] op, input logic [PATH_W-1:0] path,
                            input bit commit, output res_type w, output bit unsafe,
                            output int unsigned next_wr);
         int unsigned     o_idx, w_idx, r_idx, raw, size, dropped, start, gap, tail;
         int unsigned     guard, at, len, mark_at;
         longint unsigned o_seq, w_seq, r_seq;
         bit              put_mark, put_start;
         o_idx = oldest_idx; w_idx = write_idx; r_idx = reader_idx;
         o_seq = oldest_seq; w_seq = write_seq; r_seq = reader_seq;
         touched_blank = 1'b0;
         put_mark = 1'b0; put_start = 1'b0; mark_at = 0; start = 0; size = 0; dropped = 0;
         w = pack_word(STAT_OK, r_idx, r_seq, 0, 0);
         case (op)
            OP_APPEND: begin
               raw  = HEADER_BYTES + path + 1;
               size = ((raw + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
               if (size + LEN_WORD_BYTES >= BUF_BYTES) begin
                  w = pack_word(STAT_TOO_BIG, w_idx, w_seq, size, 0);
               end else begin
                  guard = 0;
                  while (o_seq < w_seq && guard <= SLOT_COUNT) begin
                     if (w_idx > o_idx) begin
                        tail = BUF_BYTES - w_idx;
                        gap  = (tail > o_idx) ? tail : o_idx;
                     end else begin
                        gap = o_idx - w_idx;
                     end
                     if (gap > size + LEN_WORD_BYTES) break;
                     o_idx = step_over(o_idx);
                     o_seq++;
                     dropped++;
                     guard++;
                  end
                  if (w_idx + size + LEN_WORD_BYTES >= BUF_BYTES) begin
                     put_mark = 1'b1;
                     mark_at  = w_idx;
                     w_idx    = 0;
                  end
                  start = w_idx;
                  if (o_seq == w_seq) o_idx = start;
                  put_start = 1'b1;
                  w_idx = start + size;
                  w = pack_word(STAT_OK, start, w_seq, size, dropped);
                  w_seq++;
               end
            end
            OP_READ_NEXT: begin
               if (r_seq >= w_seq) begin
                  w = pack_word(STAT_EMPTY, r_idx, r_seq, 0, 0);
               end else if (r_seq < o_seq) begin
                  r_seq = o_seq;
                  r_idx = settle(o_idx);
                  w = pack_word(STAT_OVERRUN, r_idx, r_seq, 0, 0);
               end else begin
                  at  = settle(r_idx);
                  len = slot_len(at);
                  w = pack_word(STAT_OK, at, r_seq, len, 0);
                  r_idx = step_over(at);
                  r_seq++;
               end
            end
            OP_SEEK_FIRST: begin
               r_seq = o_seq;
               r_idx = o_idx;
               w = pack_word(STAT_OK, r_idx, r_seq, 0, 0);
            end
            OP_SEEK_END: begin
               r_seq = w_seq;
               r_idx = w_idx;
               w = pack_word(STAT_OK, r_idx, r_seq, 0, 0);
            end
            OP_POLL: begin
               if (r_seq >= w_seq)
                  w = pack_word(STAT_EMPTY, r_idx, r_seq, 0, 0);
               else
                  w = pack_word((r_seq < o_seq) ? STAT_OVERRUN : STAT_OK, r_idx, r_seq, 0, 0);
            end
            default: begin
            end
         endcase
         unsafe  = touched_blank;
         next_wr = w_idx;
         if (commit) begin
            oldest_idx = o_idx; write_idx = w_idx; reader_idx = r_idx;
            oldest_seq = o_seq; write_seq = w_seq; reader_seq = r_seq;
            if (put_mark) begin
               lens[mark_at / ALIGN_BYTES]    = 0;
               written[mark_at / ALIGN_BYTES] = 1'b1;
            end
            if (put_start) begin
               lens[start / ALIGN_BYTES]    = size;
               written[start / ALIGN_BYTES] = 1'b1;
            end
            n_words++;
            if (op == OP_APPEND) begin
               if (w.status == STAT_TOO_BIG) n_too_big++;
               else begin
                  n_appends++;
                  n_dropped += dropped;
                  if (put_mark) n_wraps++;
               end
            end else if (op == OP_READ_NEXT) begin
               if (w.status == STAT_OK) n_reads++;
               else if (w.status == STAT_OVERRUN) n_overruns++;
               else n_empty++;
            end
         end
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [PATH_W-1:0] path);
         res_type     w;
         bit          unsafe;
         int unsigned nw;
         foresee(op, path, 1'b1, w, unsafe, nw);
         pending_words.push_back(w);
      endfunction

      function void check_word(res_type got);
         res_type want;
         if (pending_words.size() == 0) begin
            bad++;
            if (bad <= 10)
               $display("response word with nothing outstanding: status %0d index %0d seq %0d",
                        got.status, got.record_index, got.record_seq);
            return;
         end
         want = pending_words.pop_front();
         if (got.status !== want.status || got.record_index !== want.record_index ||
             got.record_seq !== want.record_seq || got.record_bytes !== want.record_bytes ||
             got.dropped_count !== want.dropped_count) begin
            bad++;
            if (bad <= 10)
               $display({"mismatch: status %0d/%0d index %0d/%0d seq %0d/%0d",
                         " bytes %0d/%0d drop %0d/%0d"},
                        want.status, got.status, want.record_index, got.record_index,
                        want.record_seq, got.record_seq, want.record_bytes, got.record_bytes,
                        want.dropped_count, got.dropped_count);
         end
      endfunction

      function int pending();
         return pending_words.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   vrl_req_if req_chan ();
   vrl_rsp_if rsp_chan ();

   variable_record_log_ring dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ring_bookkeeper ledger;
   int             send_idle_pct;
   int             recv_stall_pct;
   int             hold_off_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

   // response side: random stalls, plus a long hold-off when asked for
   initial begin
      res_type got;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.status        = rsp_chan.status;
            got.record_index  = rsp_chan.record_index;
            got.record_seq    = rsp_chan.record_seq;
            got.record_bytes  = rsp_chan.record_bytes;
            got.dropped_count = rsp_chan.dropped_count;
            ledger.check_word(got);
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic offer(input logic [OP_W-1:0] op, input logic [PATH_W-1:0] path);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.opcode     <= op;
      req_chan.path_bytes <= path;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      ledger.note_request(op, path);
   endtask

   // steer clear of requests that would look up a length slot never written
   task automatic issue(input logic [OP_W-1:0] op, input logic [PATH_W-1:0] path);
      res_type     w;
      bit          unsafe;
      int unsigned nw;
      ledger.foresee(op, path, 1'b0, w, unsafe, nw);
      if (op == OP_APPEND && !unsafe && w.status == STAT_OK && w.record_bytes > GIANT_BYTES &&
          !ledger.written[nw / ALIGN_BYTES])
         unsafe = 1'b1;
      if (unsafe && op == OP_APPEND) begin
         path = '0;
         ledger.foresee(op, path, 1'b0, w, unsafe, nw);
      end
      if (unsafe) op = OP_POLL;
      offer(op, path);
   endtask

   function automatic void pick_item(output logic [OP_W-1:0] op, output logic [PATH_W-1:0] path);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 45)      op = OP_APPEND;
      else if (roll < 75) op = OP_READ_NEXT;
      else if (roll < 82) op = OP_SEEK_FIRST;
      else if (roll < 87) op = OP_SEEK_END;
      else if (roll < 95) op = OP_POLL;
      else                op = OP_W'($urandom_range(7, 5));
      roll = $urandom_range(99);
      if (roll < 70)      path = PATH_W'($urandom_range(300));
      else if (roll < 88) path = PATH_W'($urandom_range(2000));
      else if (roll < 94) path = PATH_W'($urandom_range(3999, 3700));
      else if (roll < 97) path = PATH_W'($urandom_range(4095, 4000));
      else                path = PATH_W'($urandom);
   endfunction

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      issue(OP_POLL, 12'd0);          // empty ring
      issue(OP_READ_NEXT, 12'd4095);
      issue(OP_SEEK_FIRST, 12'd0);
      issue(OP_SEEK_END, 12'd0);
      issue(OP_APPEND, 12'd1959);     // two halves, second ends at 4080
      issue(OP_APPEND, 12'd1959);
      issue(OP_READ_NEXT, 12'd0);
      issue(OP_APPEND, 12'd0);        // drops one, wrap marker at 4080
      issue(OP_APPEND, 12'd1871);
      issue(OP_POLL, 12'd0);          // reader fell behind
      issue(OP_APPEND, 12'd3999);     // largest record, empties the ring
      issue(OP_READ_NEXT, 12'd0);     // overrun, back to oldest
      issue(OP_READ_NEXT, 12'd0);     // steps onto the wrap marker
      issue(OP_READ_NEXT, 12'd0);
      issue(OP_APPEND, 12'd0);
      issue(OP_POLL, 12'd0);
      issue(OP_APPEND, 12'd4095);     // too big
      issue(OP_APPEND, 12'd4000);
      issue(OP_APPEND, 12'd3992);
      issue(OP_SEEK_FIRST, 12'd0);
      issue(OP_READ_NEXT, 12'd0);
      issue(OP_SEEK_END, 12'd0);
      issue(OP_POLL, 12'd0);
      issue(3'd5, 12'd0);
      issue(3'd6, 12'hAAA);
      issue(3'd7, 12'h555);
   endtask

   initial begin
      logic [OP_W-1:0]   op;
      logic [PATH_W-1:0] path;
      ledger              = new();
      send_idle_pct       = 0;
      recv_stall_pct      = 0;
      hold_off_cycles     = 0;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.opcode     = '0;
      req_chan.path_bytes = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      drain();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         for (int n = 0; n < 160; n++) begin
            // long receiver hold-off with the sender still pushing
            if (phase == 0 && n == 40) hold_off_cycles = 300;
            pick_item(op, path);
            issue(op, path);
         end
         drain();
      end
      repeat (40) @(posedge clock);

      $display("covered %0d words: %0d appends, %0d wraps, %0d records dropped, %0d too big",
               ledger.n_words, ledger.n_appends, ledger.n_wraps, ledger.n_dropped,
               ledger.n_too_big);
      $display("reads: %0d records, %0d overruns, %0d empty; %0d mismatches",
               ledger.n_reads, ledger.n_overruns, ledger.n_empty, ledger.bad);
      if (ledger.bad == 0 && ledger.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
